// File: src/rle_pkg.sv
// Shared types and constants of the run-length encoder with literal blocks.
`default_nettype none
package rle_pkg;

   // Literal store geometry and the header flag of a literal block.
   localparam int STORE_DEPTH  = 127;
   localparam int STORE_ADDR_W = 7;
   localparam logic [7:0] LIT_FLAG = 8'h80;

   // Payload of one request: one raw byte and the end-of-stream mark.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } req_payload_type;

   // Payload of one result word: up to four encoded bytes.
   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [2:0] byte_count;
      logic       last_of_item;
   } rsp_payload_type;

   // Source of the byte that goes into the packer.
   typedef enum logic [1:0] {
      EMIT_RUN_CNT,
      EMIT_RUN_VAL,
      EMIT_LIT_HDR,
      EMIT_LIT_BODY
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_in;
      logic         dec_lit;
      logic         inc_run;
      logic         write_lit;
      logic         clear_state;
      logic         clear_run;
      logic         clear_lit;
      logic         idx_inc;
      logic         idx_clr;
      logic         emit_valid;
      emit_sel_type emit_sel;
      logic         flush;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic match;
      logic run_gt1;
      logic run_at_max_next;
      logic lit_nonzero;
      logic lit_full;
      logic is_last;
      logic idx_at_end;
      logic byte_stall;
      logic flush_done;
   } ctl_status_type;

endpackage
`default_nettype wire

// File: src/rle_chan_if.sv
// Valid/ready channel interface that carries one payload per request.
`default_nettype none
interface rle_chan_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/rle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 127
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: src/rle_datapath.sv
// Encoder datapath: stream state, literal store, word packer and result register.
`default_nettype none
module rle_datapath #(
   parameter int MAX_SEQ = 127
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rle_pkg::req_payload_type req_payload,
   input  wire rle_pkg::ctl_cmd_type     cmd,
   output rle_pkg::ctl_status_type       status,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rle_pkg::rsp_payload_type      rsp_payload
);

   // Latched request and stream state.
   logic [7:0] in_byte_ff, in_byte_in;
   logic       is_last_ff, is_last_in;
   logic [7:0] prev_ff, prev_in;
   logic [6:0] run_len_ff, run_len_in;
   logic [6:0] lit_cnt_ff, lit_cnt_in;
   logic [rle_pkg::STORE_ADDR_W-1:0] idx_ff, idx_in;

   // Packer staging word and result register.
   logic [3:0][7:0] stage_ff, stage_in;
   logic [2:0]      stage_cnt_ff, stage_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rle_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [7:0] ram_rdata;
   logic [rle_pkg::STORE_ADDR_W-1:0] ram_raddr;
   logic [7:0] emit_byte;
   logic       can_push;
   logic       byte_stall;
   logic       taken;
   logic       push;
   logic [1:0] wr_slot;

   // The read address moves ahead as soon as a body byte is taken.
   assign ram_raddr = idx_ff + rle_pkg::STORE_ADDR_W'(cmd.idx_inc);

   rle_ram #(
      .WIDTH (8),
      .DEPTH (rle_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.write_lit),
      .waddr (lit_cnt_ff),
      .wdata (in_byte_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Select the encoded byte offered to the packer.
   always_comb begin
      case (cmd.emit_sel)
         rle_pkg::EMIT_RUN_CNT:  emit_byte = {1'b0, run_len_ff};
         rle_pkg::EMIT_RUN_VAL:  emit_byte = prev_ff;
         rle_pkg::EMIT_LIT_HDR:  emit_byte = rle_pkg::LIT_FLAG | {1'b0, lit_cnt_ff};
         rle_pkg::EMIT_LIT_BODY: emit_byte = ram_rdata;
         default:                emit_byte = prev_ff;
      endcase
   end

   // Packer handshake: a full staging word moves out when the result register frees.
   assign can_push   = !rsp_valid_ff || rsp_ready;
   assign byte_stall = (stage_cnt_ff == 3'd4) && !can_push;
   assign taken      = cmd.emit_valid && !byte_stall;
   assign push       = (taken && (stage_cnt_ff == 3'd4)) ||
                       (cmd.flush && (stage_cnt_ff != 3'd0) && can_push);
   assign wr_slot    = push ? 2'd0 : stage_cnt_ff[1:0];

   // Next values of the stream state.
   always_comb begin
      in_byte_in = in_byte_ff;
      is_last_in = is_last_ff;
      if (cmd.load_in) begin
         in_byte_in = req_payload.in_byte;
         is_last_in = req_payload.is_last;
      end

      prev_in = prev_ff;
      if (cmd.clear_state) begin
         prev_in = 8'd0;
      end else if (cmd.write_lit) begin
         prev_in = in_byte_ff;
      end

      run_len_in = run_len_ff;
      if (cmd.clear_state || cmd.clear_run) begin
         run_len_in = 7'd0;
      end else if (cmd.write_lit) begin
         run_len_in = 7'd1;
      end else if (cmd.inc_run) begin
         run_len_in = run_len_ff + 7'd1;
      end

      lit_cnt_in = lit_cnt_ff;
      if (cmd.clear_state || cmd.clear_lit) begin
         lit_cnt_in = 7'd0;
      end else if (cmd.dec_lit) begin
         lit_cnt_in = lit_cnt_ff - 7'd1;
      end else if (cmd.write_lit) begin
         lit_cnt_in = lit_cnt_ff + 7'd1;
      end

      idx_in = idx_ff;
      if (cmd.idx_clr || cmd.clear_state) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + rle_pkg::STORE_ADDR_W'(1);
      end
   end

   // Next values of the packer and the result register.
   always_comb begin
      stage_in     = stage_ff;
      stage_cnt_in = stage_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (push) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_byte0    = stage_ff[0];
         rsp_data_in.out_byte1    = stage_ff[1];
         rsp_data_in.out_byte2    = stage_ff[2];
         rsp_data_in.out_byte3    = stage_ff[3];
         rsp_data_in.byte_count   = stage_cnt_ff;
         rsp_data_in.last_of_item = cmd.flush;
         stage_cnt_in             = 3'd0;
      end

      if (taken) begin
         // A fresh word starts with its unused bytes at zero.
         if (wr_slot == 2'd0) begin
            stage_in = '0;
         end
         stage_in[wr_slot] = emit_byte;
         stage_cnt_in      = {1'b0, wr_slot} + 3'd1;
      end
   end

   // Registers: control state is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 8'd0;
         run_len_ff   <= 7'd0;
         lit_cnt_ff   <= 7'd0;
         idx_ff       <= '0;
         stage_cnt_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         run_len_ff   <= run_len_in;
         lit_cnt_ff   <= lit_cnt_in;
         idx_ff       <= idx_in;
         stage_cnt_ff <= stage_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      is_last_ff  <= is_last_in;
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status toward the controller.
   always_comb begin
      status.match           = (run_len_ff != 7'd0) && (in_byte_ff == prev_ff);
      status.run_gt1         = run_len_ff > 7'd1;
      status.run_at_max_next = ({1'b0, run_len_ff} + 8'd1) >= 8'(MAX_SEQ);
      status.lit_nonzero     = lit_cnt_ff != 7'd0;
      status.lit_full        = lit_cnt_ff >= 7'(MAX_SEQ);
      status.is_last         = is_last_ff;
      status.idx_at_end      = idx_ff == (lit_cnt_ff - 7'd1);
      status.byte_stall      = byte_stall;
      status.flush_done      = (stage_cnt_ff == 3'd0) || can_push;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

// File: src/rle_ctrl.sv
// Encoder controller: sequences run and literal-block emission for one request.
`default_nettype none
module rle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire rle_pkg::ctl_status_type status,
   output rle_pkg::ctl_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_A_LIT,
      S_A_INC,
      S_B_LIT,
      S_B_WRITE,
      S_LAST,
      S_LAST_RUN,
      S_CLEAR,
      S_FLUSH,
      S_RUN_CNT,
      S_RUN_VAL,
      S_LIT_HDR,
      S_LIT_BODY
   } state_type;

   // The return state is where a run or literal-block emission goes when done.
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state, return state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd          = '0;
      cmd.emit_sel = rle_pkg::EMIT_RUN_CNT;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.match) begin
               // The byte that opened the run leaves the literal store.
               cmd.dec_lit = status.lit_nonzero;
               state_in    = S_A_LIT;
            end else if (status.run_gt1) begin
               state_in = S_RUN_CNT;
               ret_in   = S_B_LIT;
            end else begin
               state_in = S_B_LIT;
            end
         end
         S_A_LIT: begin
            if (status.lit_nonzero) begin
               state_in = S_LIT_HDR;
               ret_in   = S_A_INC;
            end else begin
               state_in = S_A_INC;
            end
         end
         S_A_INC: begin
            cmd.inc_run = 1'b1;
            if (status.run_at_max_next) begin
               state_in = S_RUN_CNT;
               ret_in   = S_LAST;
            end else begin
               state_in = S_LAST;
            end
         end
         S_B_LIT: begin
            if (status.lit_full) begin
               state_in = S_LIT_HDR;
               ret_in   = S_B_WRITE;
            end else begin
               state_in = S_B_WRITE;
            end
         end
         S_B_WRITE: begin
            cmd.write_lit = 1'b1;
            state_in      = S_LAST;
         end
         S_LAST: begin
            if (!status.is_last) begin
               state_in = S_FLUSH;
            end else if (status.lit_nonzero) begin
               state_in = S_LIT_HDR;
               ret_in   = S_LAST_RUN;
            end else begin
               state_in = S_LAST_RUN;
            end
         end
         S_LAST_RUN: begin
            if (status.run_gt1) begin
               state_in = S_RUN_CNT;
               ret_in   = S_CLEAR;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clear_state = 1'b1;
            state_in        = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (status.flush_done) begin
               state_in = S_IDLE;
            end
         end
         S_RUN_CNT: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_sel   = rle_pkg::EMIT_RUN_CNT;
            if (!status.byte_stall) begin
               state_in = S_RUN_VAL;
            end
         end
         S_RUN_VAL: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_sel   = rle_pkg::EMIT_RUN_VAL;
            if (!status.byte_stall) begin
               cmd.clear_run = 1'b1;
               state_in      = ret_ff;
            end
         end
         S_LIT_HDR: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_sel   = rle_pkg::EMIT_LIT_HDR;
            if (!status.byte_stall) begin
               state_in = S_LIT_BODY;
            end
         end
         S_LIT_BODY: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_sel   = rle_pkg::EMIT_LIT_BODY;
            if (!status.byte_stall) begin
               if (status.idx_at_end) begin
                  cmd.clear_lit = 1'b1;
                  cmd.idx_clr   = 1'b1;
                  state_in      = ret_ff;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule
`default_nettype wire

// File: src/rle_literal_run_encoder.sv
// Top level of the byte-stream run-length encoder with literal blocks.
// A request runs from its accepting cycle through the final flush, and longer when it ends
// the stream; each encoded byte and any output stall add to that time.
// Throughput: one request at a time; the byte-serial emission sets the rate.
// A result word waits in an output register while the next request is taken.
// Reset is synchronous and clears the stream state; the literal store needs no clearing.
`default_nettype none
module rle_literal_run_encoder #(
   parameter int MAX_SEQ = 127
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rle_chan_if.sink    req_chan,
   rle_chan_if.source  rsp_chan
);

   rle_pkg::ctl_cmd_type    cmd;
   rle_pkg::ctl_status_type status;

   // Controller.
   rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   rle_datapath #(
      .MAX_SEQ (MAX_SEQ)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

   // No byte is emitted while a new request can be taken.
   a_ready_no_emit: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !cmd.emit_valid)
      else $error("byte emitted while idle");

   // A literal body byte is only read while the store holds entries.
   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_valid && (cmd.emit_sel == rle_pkg::EMIT_LIT_BODY)) |-> status.lit_nonzero)
      else $error("literal body emitted from an empty store");

   // The packer stalls only while the result register is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      status.byte_stall |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("packer stalled without a held result");

   // A result word carries one to four bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.payload.byte_count != 3'd0) &&
                          (rsp_chan.payload.byte_count <= 3'd4)))
      else $error("result word byte count out of range");

endmodule
`default_nettype wire
